// ----- rtl/particle_euler_circle_bounce_top_macros.svh -----
// Assertion macros shared by the particle step block.
`ifndef PARTICLE_EULER_CIRCLE_BOUNCE_TOP_MACROS_SVH
`define PARTICLE_EULER_CIRCLE_BOUNCE_TOP_MACROS_SVH
// Implication that is checked on every rising clock edge outside reset.
`define PECB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define PECB_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/pecb_pkg.sv -----
// ----------------------------------------------------------------------------
// pecb_pkg
// Widths and pipeline types shared by the particle step block.
// ----------------------------------------------------------------------------
package pecb_pkg;
  localparam int unsigned W   = 24;
  localparam int unsigned F   = 12;
  // The squared distance fits in 2*(W+1)+1 bits; the root in W+1 bits.
  localparam int unsigned DW  = W + 2;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned RW  = DW;
  localparam int unsigned NQ  = F + 2;         // normal magnitude bits (<= 2^F)
  // Widest dividend: |d| * radius << F, with |d| below 2^W and radius below 2^11.
  localparam int unsigned DQW = W + 11 + F;
  localparam int unsigned CELLS = RW;          // one root bit per cell
  localparam int unsigned DAMP_BITS = 12;      // damping is Q1.12

  typedef struct packed {
    logic                  valid;
    logic signed [W-1:0]   vx;
    logic signed [W-1:0]   vy;
    logic signed [W-1:0]   px;
    logic signed [W-1:0]   py;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic [SQW-1:0]        rem;
    logic [RW-1:0]         root;
    logic [SQW-1:0]        sq;
  } sq_beat_t;

  typedef struct packed {
    logic                  valid;
    logic signed [W-1:0]   vx;
    logic signed [W-1:0]   vy;
    logic signed [W-1:0]   px;
    logic signed [W-1:0]   py;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic [RW-1:0]         dlen;
    logic                  hit;
    // four restoring dividers run in lockstep: |dx|<<F, |dy|<<F, |dx|*R<<F, |dy|*R<<F
    logic [DQW-1:0]        nrx;
    logic [DQW-1:0]        nry;
    logic [DQW-1:0]        prx;
    logic [DQW-1:0]        pry;
    logic [DQW-1:0]        qnx;
    logic [DQW-1:0]        qny;
    logic [DQW-1:0]        qpx;
    logic [DQW-1:0]        qpy;
    logic [DQW-1:0]        anx;
    logic [DQW-1:0]        any_;
    logic [DQW-1:0]        apx;
    logic [DQW-1:0]        apy;
  } dv_beat_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd1 <<< (W - 1);
    lo = -hi;
    hi = hi - 64'sd1;
    if (v > hi) return hi[W-1:0];
    if (v < lo) return lo[W-1:0];
    return v[W-1:0];
  endfunction

  // Division by 2^sh that rounds toward zero, done as a biased arithmetic shift.
  function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< sh) - 64'sd1;
    if (v < 0) return (v + bias) >>> sh;
    return v >>> sh;
  endfunction
endpackage

// ----- rtl/pecb_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// pecb_sqrt_cell
// One cell of the square-root chain: settles one root bit per cycle while en_i is high.
// ----------------------------------------------------------------------------
module pecb_sqrt_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  pecb_pkg::sq_beat_t  in_i,
  output pecb_pkg::sq_beat_t  out_o
);
  pecb_pkg::sq_beat_t beat_d, beat_q;
  logic [pecb_pkg::SQW-1:0] rem_sh;
  logic [pecb_pkg::SQW-1:0] trial;

  // Bring down the next two radicand bits and try the subtraction.
  always_comb begin
    beat_d = in_i;
    rem_sh = {in_i.rem[pecb_pkg::SQW-3:0], in_i.sq[2*Bit+1 -: 2]};
    trial  = {{(pecb_pkg::SQW-pecb_pkg::RW-2){1'b0}}, in_i.root, 2'b01};
    if (rem_sh >= trial) begin
      beat_d.rem  = rem_sh - trial;
      beat_d.root = {in_i.root[pecb_pkg::RW-2:0], 1'b1};
    end else begin
      beat_d.rem  = rem_sh;
      beat_d.root = {in_i.root[pecb_pkg::RW-2:0], 1'b0};
    end
  end

  // The cell holds its beat while the chain is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end
  assign out_o = beat_q;
endmodule

// ----- rtl/pecb_div_cell.sv -----
// ----------------------------------------------------------------------------
// pecb_div_cell
// One cell of the divider chain: one quotient bit of four lockstep divides.
// ----------------------------------------------------------------------------
module pecb_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  pecb_pkg::dv_beat_t  in_i,
  output pecb_pkg::dv_beat_t  out_o
);
  localparam int unsigned N = pecb_pkg::DQW;
  pecb_pkg::dv_beat_t beat_d, beat_q;

  function automatic void step(input logic [N-1:0] r, input logic [N-1:0] q,
                               input logic [N-1:0] a, input logic [N-1:0] d,
                               output logic [N-1:0] ro, output logic [N-1:0] qo);
    logic [N:0] t;
    t = {r, a[Bit]};
    if (t >= {1'b0, d}) begin
      ro = N'(t - {1'b0, d});
      qo = q | (N'(1) << Bit);
    end else begin
      ro = t[N-1:0];
      qo = q;
    end
  endfunction

  // Restoring step on all four dividends against the shared divisor.
  always_comb begin
    logic [N-1:0] dv;
    dv = N'(in_i.dlen);
    beat_d = in_i;
    step(in_i.nrx, in_i.qnx, in_i.anx,  dv, beat_d.nrx, beat_d.qnx);
    step(in_i.nry, in_i.qny, in_i.any_, dv, beat_d.nry, beat_d.qny);
    step(in_i.prx, in_i.qpx, in_i.apx,  dv, beat_d.prx, beat_d.qpx);
    step(in_i.pry, in_i.qpy, in_i.apy,  dv, beat_d.pry, beat_d.qpy);
  end

  // The cell holds its beat while the chain is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end
  assign out_o = beat_q;
endmodule

// ----- rtl/particle_euler_circle_bounce_top.sv -----
// ----------------------------------------------------------------------------
// particle_euler_circle_bounce_top
// Euler step of one particle with reflection off a circular wall.
// ----------------------------------------------------------------------------
// One particle enters per cycle while the output is not stalled and passes
// through two Euler stages, 26 square-root cells (one root bit each), one
// setup stage, 47 divider cells (one quotient bit each), then three stages of
// reflection multiplies and an output register. The whole chain advances only
// while the output side takes its beat or is empty, so a stall at the output
// holds every particle in place and tready follows it.
`include "particle_euler_circle_bounce_top_macros.svh"
module particle_euler_circle_bounce_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // pos_x[23:0], pos_y[47:24], vel_x[71:48], vel_y[95:72]
  input  logic [95:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // new_pos_x[23:0], new_pos_y[47:24], new_vel_x[71:48], new_vel_y[95:72],
  // hit_wall[96], zeros above
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int unsigned W = pecb_pkg::W;
  localparam int unsigned F = pecb_pkg::F;
  localparam int unsigned DW = pecb_pkg::DW;
  localparam int unsigned N = pecb_pkg::DQW;
  localparam logic [4:0] AddrGravity = 5'd0;
  localparam logic [4:0] AddrDamping = 5'd4;
  localparam logic [4:0] AddrRadius  = 5'd8;
  localparam logic [4:0] AddrCx      = 5'd12;
  localparam logic [4:0] AddrCy      = 5'd16;

  // Configuration registers.
  logic [15:0] gravity_q;
  logic [12:0] damping_q;
  logic [10:0] radius_q, cx_q, cy_q;
  logic        wr;
  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= 16'd2048; damping_q <= 13'd3277; radius_q <= 11'd350;
      cx_q <= 11'd400; cy_q <= 11'd400;
    end else if (wr) begin
      case (paddr)
        AddrGravity: gravity_q <= pwdata[15:0];
        AddrDamping: damping_q <= pwdata[12:0];
        AddrRadius:  radius_q  <= pwdata[10:0];
        AddrCx:      cx_q      <= pwdata[10:0];
        AddrCy:      cy_q      <= pwdata[10:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      AddrGravity: prdata = {16'd0, gravity_q};
      AddrDamping: prdata = {19'd0, damping_q};
      AddrRadius:  prdata = {21'd0, radius_q};
      AddrCx:      prdata = {21'd0, cx_q};
      AddrCy:      prdata = {21'd0, cy_q};
      default:     prdata = 32'd0;
    endcase
  end

  // Global advance: the chain moves when the output register can take a beat.
  logic adv;
  logic out_v_q;
  assign adv = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Euler stage 1: gravity and horizontal position.
  logic                v1_q;
  logic signed [W-1:0] px1_q, vx1_q, vy1_q, py0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx1_q <= s_axis_tdata[71:48];
      vy1_q <= pecb_pkg::sat_w(64'(signed'(s_axis_tdata[95:72])) + 64'(gravity_q));
      px1_q <= pecb_pkg::sat_w(64'(signed'(s_axis_tdata[23:0]))
                               + 64'(signed'(s_axis_tdata[71:48])));
      py0_q <= s_axis_tdata[47:24];
    end
  end

  // Euler stage 2: vertical position, offsets from the centre and squares.
  logic signed [W-1:0] py1;
  logic signed [DW-1:0] dxs, dys;
  logic [DW-1:0] mx, my;
  always_comb begin
    py1 = pecb_pkg::sat_w(64'(py0_q) + 64'(vy1_q));
    dxs = DW'(px1_q) - DW'({cx_q, {F{1'b0}}});
    dys = DW'(py1) - DW'({cy_q, {F{1'b0}}});
    mx  = dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
    my  = dys[DW-1] ? DW'(-dys) : DW'(dys);
  end
  pecb_pkg::sq_beat_t sq_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= '0;
    end else if (adv) begin
      sq_q.valid <= v1_q;
      sq_q.vx <= vx1_q; sq_q.vy <= vy1_q; sq_q.px <= px1_q; sq_q.py <= py1;
      sq_q.dx <= dxs; sq_q.dy <= dys;
      sq_q.rem <= '0; sq_q.root <= '0;
      sq_q.sq <= pecb_pkg::SQW'(mx) * pecb_pkg::SQW'(mx)
               + pecb_pkg::SQW'(my) * pecb_pkg::SQW'(my);
    end
  end

  // Square-root chain, one cell per root bit (most significant first).
  pecb_pkg::sq_beat_t sq_c [pecb_pkg::CELLS+1];
  assign sq_c[0] = sq_q;
  for (genvar i = 0; i < pecb_pkg::CELLS; i++) begin : g_sq
    pecb_sqrt_cell #(.Bit(pecb_pkg::CELLS - 1 - i)) u_cell (
      .clk_i, .rst_ni, .en_i(adv), .in_i(sq_c[i]), .out_o(sq_c[i+1]));
  end
  pecb_pkg::sq_beat_t sq_end;
  assign sq_end = sq_c[pecb_pkg::CELLS];

  // Setup stage: hit test and divider operands.
  pecb_pkg::dv_beat_t dv_q;
  logic [DW-1:0] ax, ay;
  logic [pecb_pkg::RW-1:0] rfix;
  always_comb begin
    ax = sq_end.dx[DW-1] ? DW'(-sq_end.dx) : DW'(sq_end.dx);
    ay = sq_end.dy[DW-1] ? DW'(-sq_end.dy) : DW'(sq_end.dy);
    rfix = pecb_pkg::RW'({radius_q, {F{1'b0}}});
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (adv) begin
      dv_q.valid <= sq_end.valid;
      dv_q.vx <= sq_end.vx; dv_q.vy <= sq_end.vy;
      dv_q.px <= sq_end.px; dv_q.py <= sq_end.py;
      dv_q.dx <= sq_end.dx; dv_q.dy <= sq_end.dy;
      dv_q.dlen <= sq_end.root;
      dv_q.hit <= sq_end.root > rfix;
      dv_q.nrx <= '0; dv_q.nry <= '0; dv_q.prx <= '0; dv_q.pry <= '0;
      dv_q.qnx <= '0; dv_q.qny <= '0; dv_q.qpx <= '0; dv_q.qpy <= '0;
      dv_q.anx <= N'({ax, {F{1'b0}}});
      dv_q.any_ <= N'({ay, {F{1'b0}}});
      dv_q.apx <= (N'(ax) * N'(radius_q)) << F;
      dv_q.apy <= (N'(ay) * N'(radius_q)) << F;
    end
  end

  // Divider chain, one cell per quotient bit.
  pecb_pkg::dv_beat_t dv_c [N+1];
  assign dv_c[0] = dv_q;
  for (genvar j = 0; j < N; j++) begin : g_dv
    pecb_div_cell #(.Bit(N - 1 - j)) u_cell (
      .clk_i, .rst_ni, .en_i(adv), .in_i(dv_c[j]), .out_o(dv_c[j+1]));
  end
  pecb_pkg::dv_beat_t de;
  assign de = dv_c[N];

  // Reflection stage A: signed normal, projected position, dot-product terms.
  logic                 ra_v_q, ra_hit_q;
  logic signed [W-1:0]  ra_vx_q, ra_vy_q, ra_px_q, ra_py_q;
  logic signed [pecb_pkg::NQ:0] nx_q, ny_q;
  logic signed [63:0]   dpx_q, dpy_q;
  logic signed [pecb_pkg::NQ:0] nx_w, ny_w;
  logic signed [63:0]   ppx, ppy;
  always_comb begin
    nx_w = de.dx[DW-1] ? -$signed({1'b0, de.qnx[pecb_pkg::NQ-1:0]})
                       :  $signed({1'b0, de.qnx[pecb_pkg::NQ-1:0]});
    ny_w = de.dy[DW-1] ? -$signed({1'b0, de.qny[pecb_pkg::NQ-1:0]})
                       :  $signed({1'b0, de.qny[pecb_pkg::NQ-1:0]});
    ppx = de.dx[DW-1] ? -64'(de.qpx) : 64'(de.qpx);
    ppy = de.dy[DW-1] ? -64'(de.qpy) : 64'(de.qpy);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ra_v_q <= 1'b0;
    else if (adv) ra_v_q <= de.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ra_hit_q <= de.hit;
      ra_vx_q <= de.vx; ra_vy_q <= de.vy;
      ra_px_q <= de.hit ? pecb_pkg::sat_w(64'({cx_q, {F{1'b0}}}) + ppx) : de.px;
      ra_py_q <= de.hit ? pecb_pkg::sat_w(64'({cy_q, {F{1'b0}}}) + ppy) : de.py;
      nx_q <= nx_w; ny_q <= ny_w;
      dpx_q <= de.vx * nx_w;
      dpy_q <= de.vy * ny_w;
    end
  end

  // Reflection stage B: dot product and its projection onto the normal.
  logic                 rb_v_q, rb_hit_q;
  logic signed [W-1:0]  rb_vx_q, rb_vy_q, rb_px_q, rb_py_q;
  logic signed [63:0]   rfx_q, rfy_q;
  logic signed [W+1:0]  dot;
  always_comb dot = (W+2)'(pecb_pkg::shr_trunc(dpx_q + dpy_q, F));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rb_v_q <= 1'b0;
    else if (adv) rb_v_q <= ra_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rb_hit_q <= ra_hit_q;
      rb_vx_q <= ra_vx_q; rb_vy_q <= ra_vy_q; rb_px_q <= ra_px_q; rb_py_q <= ra_py_q;
      rfx_q <= dot * nx_q;
      rfy_q <= dot * ny_q;
    end
  end

  // Reflection stage C: subtract and damp; the output register saturates.
  logic                 rc_v_q, rc_hit_q;
  logic signed [W-1:0]  rc_px_q, rc_py_q, rc_vx_q, rc_vy_q;
  logic signed [63:0]   mvx_q, mvy_q;
  logic signed [W+3:0]  wvx, wvy;
  logic signed [13:0]   damp_s;
  always_comb begin
    wvx = (W+4)'(64'(rb_vx_q) - 64'sd2 * pecb_pkg::shr_trunc(rfx_q, F));
    wvy = (W+4)'(64'(rb_vy_q) - 64'sd2 * pecb_pkg::shr_trunc(rfy_q, F));
    damp_s = $signed({1'b0, damping_q});
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rc_v_q <= 1'b0;
    else if (adv) rc_v_q <= rb_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rc_hit_q <= rb_hit_q;
      rc_px_q <= rb_px_q; rc_py_q <= rb_py_q; rc_vx_q <= rb_vx_q; rc_vy_q <= rb_vy_q;
      mvx_q <= wvx * damp_s;
      mvy_q <= wvy * damp_s;
    end
  end

  // Output register.
  logic [103:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= rc_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {7'd0, rc_hit_q,
        rc_hit_q ? pecb_pkg::sat_w(pecb_pkg::shr_trunc(mvy_q, pecb_pkg::DAMP_BITS))
                 : rc_vy_q,
        rc_hit_q ? pecb_pkg::sat_w(pecb_pkg::shr_trunc(mvx_q, pecb_pkg::DAMP_BITS))
                 : rc_vx_q,
        rc_py_q, rc_px_q};
    end
  end
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  `PECB_ASSERT_NXT(a_hold_out, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
  `PECB_ASSERT_IMP(a_ready, clk_i, rst_ni, !m_axis_tvalid,
    s_axis_tready, "input stalled with empty output")
  `PECB_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tdata[103:97] == 7'd0, "padding bits not zero")
endmodule
